### design/ctpd_pkg.sv
// ----------------------------------------------------------------------------
// ctpd_pkg
// Shared constants, register codes, sequencer states and unit status type
// for the cubic trajectory PD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ctpd_pkg;

  // default fixed point format
  localparam int unsigned DEF_WORD_BITS = 32;
  localparam int unsigned DEF_FRAC_BITS = 16;

  // multiplier digit width, one digit of the second operand per cycle
  localparam int unsigned DIG_W = 16;

  // configuration index width
  localparam int unsigned CFG_IDX_W = 3;

  // end of the trajectory window in seconds
  localparam int unsigned TRAJ_END_S = 20;

  // pi/2 in unsigned Q32 (rounded down), rounded to nearest into the format at elaboration
  localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_DERIV = 3'd1,
    REG_COEF_CONST = 3'd2,
    REG_COEF_LIN   = 3'd3,
    REG_COEF_QUAD  = 3'd4,
    REG_COEF_CUBE  = 3'd5,
    REG_HOLD_ANGLE = 3'd6
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T2,
    ST_T3,
    ST_P1,
    ST_S1,
    ST_P2,
    ST_S2,
    ST_P3,
    ST_S3,
    ST_ERR,
    ST_DIFF,
    ST_RATE,
    ST_PK,
    ST_PD,
    ST_U,
    ST_EFF,
    ST_OUT
  } ctl_state_e;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic done;
    logic clip;
  } unit_stat_t;

endpackage

`default_nettype wire

### design/ctpd_if.sv
// ----------------------------------------------------------------------------
// ctpd channel interfaces
// Valid/ready channels for tick words, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// one control tick
interface ctpd_in_if #(
  parameter int unsigned WORD_BITS = ctpd_pkg::DEF_WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic        [WORD_BITS-1:0] elapsed_time;
  logic        [WORD_BITS-1:0] tick_period;
  logic signed [WORD_BITS-1:0] joint_angle;

  modport source (output valid, output elapsed_time, output tick_period,
                  output joint_angle, input ready);
  modport sink   (input valid, input elapsed_time, input tick_period,
                  input joint_angle, output ready);
endinterface

// one effort result
interface ctpd_out_if #(
  parameter int unsigned WORD_BITS = ctpd_pkg::DEF_WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] effort_cmd;
  logic                        loop_enabled;
  logic                        zero_period;
  logic                        saturated;

  modport source (output valid, output effort_cmd, output loop_enabled,
                  output zero_period, output saturated, input ready);
  modport sink   (input valid, input effort_cmd, input loop_enabled,
                  input zero_period, input saturated, output ready);
endinterface

// register write
interface ctpd_cfg_if #(
  parameter int unsigned WORD_BITS = ctpd_pkg::DEF_WORD_BITS
);
  logic                           valid;
  logic                           ready;
  logic [ctpd_pkg::CFG_IDX_W-1:0] index;
  logic [WORD_BITS-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/ctpd_mul.sv
// ----------------------------------------------------------------------------
// ctpd_mul
// Iterative signed fixed point multiplier: one 16-bit digit per cycle,
// product shifted down by the fraction bits, magnitude truncated and
// saturated to the signed word range.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpd_mul #(
  parameter int unsigned WORD_BITS = ctpd_pkg::DEF_WORD_BITS,
  parameter int unsigned FRAC_BITS = ctpd_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [WORD_BITS:0]   a_i,
  input  wire logic signed [WORD_BITS:0]   b_i,
  output      logic signed [WORD_BITS-1:0] res_o,
  output      ctpd_pkg::unit_stat_t        stat_o
);

  localparam int unsigned DIG_W = ctpd_pkg::DIG_W;
  localparam int unsigned ND    = (WORD_BITS + DIG_W - 1) / DIG_W;
  localparam int unsigned Y_W   = ND * DIG_W;
  localparam int unsigned ACC_W = Y_W + WORD_BITS;
  localparam int unsigned M_W   = ACC_W - FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(ND + 1);

  logic [WORD_BITS-1:0]       x_q;
  logic [Y_W-1:0]             y_q;
  logic                       neg_q;
  logic [ACC_W-1:0]           acc_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q;
  logic                       fin_q;

  logic [WORD_BITS:0]         a_mag;
  logic [WORD_BITS:0]         b_mag;
  logic [DIG_W-1:0]           digit;
  logic [WORD_BITS+DIG_W-1:0] partial;
  logic [ACC_W-1:0]           acc_next;
  logic [M_W-1:0]             m;
  logic [M_W-1:0]             lim_pos;
  logic [M_W-1:0]             lim;
  logic                       clip;
  logic [WORD_BITS-1:0]       mag_w;

  // operand magnitudes
  assign a_mag = a_i[WORD_BITS] ? -a_i : a_i;
  assign b_mag = b_i[WORD_BITS] ? -b_i : b_i;

  // one digit of y times x, accumulated most significant digit first
  assign digit    = y_q[Y_W-1 -: DIG_W];
  assign partial  = x_q * digit;
  assign acc_next = {acc_q[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}} + ACC_W'(partial);

  // scale down, clip magnitude, apply sign
  assign m       = acc_q[ACC_W-1:FRAC_BITS];
  assign lim_pos = (M_W'(1) << (WORD_BITS - 1)) - M_W'(1);
  assign lim     = neg_q ? lim_pos + M_W'(1) : lim_pos;
  assign clip    = m > lim;
  assign mag_w   = clip ? lim[WORD_BITS-1:0] : m[WORD_BITS-1:0];
  assign res_o   = neg_q ? -mag_w : mag_w;

  assign stat_o.done = fin_q;
  assign stat_o.clip = clip;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ND);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= a_mag[WORD_BITS-1:0];
      y_q   <= Y_W'(b_mag[WORD_BITS-1:0]);
      neg_q <= a_i[WORD_BITS] ^ b_i[WORD_BITS];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_next;
      y_q   <= y_q << DIG_W;
    end
  end

endmodule

`default_nettype wire

### design/ctpd_div.sv
// ----------------------------------------------------------------------------
// ctpd_div
// Restoring divider for the angle rate: (|num| << FRAC_BITS) / den, one
// quotient bit per cycle, magnitude truncated and saturated to the word.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpd_div #(
  parameter int unsigned WORD_BITS = ctpd_pkg::DEF_WORD_BITS,
  parameter int unsigned FRAC_BITS = ctpd_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [WORD_BITS-1:0] num_i,
  input  wire logic        [WORD_BITS-1:0] den_i,
  output      logic signed [WORD_BITS-1:0] res_o,
  output      ctpd_pkg::unit_stat_t        stat_o
);

  localparam int unsigned NUM_W = WORD_BITS + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]     sh_q;
  logic [WORD_BITS-1:0] rem_q;
  logic [WORD_BITS-1:0] den_q;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 fin_q;

  logic [WORD_BITS-1:0] num_mag;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   trial_sub;
  logic                 ge;
  logic [NUM_W-1:0]     lim_pos;
  logic [NUM_W-1:0]     lim;
  logic                 clip;
  logic [WORD_BITS-1:0] mag_w;

  assign num_mag = num_i[WORD_BITS-1] ? -num_i : num_i;

  // one restoring step
  assign trial     = {rem_q, sh_q[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = trial >= {1'b0, den_q};

  // quotient clip and sign
  assign lim_pos = (NUM_W'(1) << (WORD_BITS - 1)) - NUM_W'(1);
  assign lim     = neg_q ? lim_pos + NUM_W'(1) : lim_pos;
  assign clip    = sh_q > lim;
  assign mag_w   = clip ? lim[WORD_BITS-1:0] : sh_q[WORD_BITS-1:0];
  assign res_o   = neg_q ? -mag_w : mag_w;

  assign stat_o.done = fin_q;
  assign stat_o.clip = clip;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // numerator bits shift out the top, quotient bits shift in the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[WORD_BITS-1];
    end else if (busy_q) begin
      sh_q  <= {sh_q[NUM_W-2:0], ge};
      rem_q <= ge ? trial_sub[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### design/cubic_trajectory_pd_controller.sv
// Sequence: before the loop is enabled a tick goes straight to the output;
// once enabled, 8 multiplies, one divide and the adder steps, fewer outside
// the trajectory window (no setpoint multiplies) or for a zero period (no
// divide); the default format is Q16.16. One tick word at a time; the next
// is taken while a finished result waits in the output register.
// Reset clears gains, coefficients, previous angle and enable latch; hold_angle is pi/2.
// ----------------------------------------------------------------------------
// cubic_trajectory_pd_controller
// One joint PD position loop with a cubic setpoint, sequenced over a shared
// iterative multiplier, a shared saturating adder and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_trajectory_pd_controller #(
  parameter int unsigned WORD_BITS = ctpd_pkg::DEF_WORD_BITS,
  parameter int unsigned FRAC_BITS = ctpd_pkg::DEF_FRAC_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ctpd_in_if.sink   in_i,
  ctpd_out_if.source out_o,
  ctpd_cfg_if.sink  cfg_i
);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   wide_t;

  localparam int unsigned T_W = WORD_BITS + 6;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;
  localparam logic [T_W-1:0] T_END = T_W'(ctpd_pkg::TRAJ_END_S) << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] TENTH_Q =
    WORD_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [63:0] HOLD_RAW =
    (ctpd_pkg::HALF_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [WORD_BITS-1:0] HOLD_RESET = HOLD_RAW[WORD_BITS-1:0];
  localparam word_t W_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t W_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  // configuration registers
  word_t gp_q, gd_q, c0_q, c1_q, c2_q, c3_q, hold_q;

  // sequencer and datapath registers
  ctpd_pkg::ctl_state_e state_q, state_d;
  logic [WORD_BITS-1:0] t_q, t_d;
  logic [WORD_BITS-1:0] dt_q, dt_d;
  word_t ang_q, ang_d;
  word_t prev_q, prev_d;
  logic  en_q, en_d;
  word_t t2_q, t2_d;
  word_t t3_q, t3_d;
  word_t sp_q, sp_d;
  word_t err_q, err_d;
  word_t rate_q, rate_d;
  word_t prod_q, prod_d;
  logic  clip_q, clip_d;
  logic  wait_q, wait_d;

  // output register
  logic  out_valid_q, out_valid_d;
  word_t out_eff_q;
  logic  out_en_q, out_zp_q, out_sat_q;
  logic  out_load;

  // arithmetic units
  logic                 mul_start, div_start;
  wide_t                mul_a, mul_b;
  word_t                mul_res, div_res;
  ctpd_pkg::unit_stat_t mul_stat, div_stat;

  word_t add_a, add_b, add_res;
  logic  add_sub, add_clip;
  wide_t add_sum;

  logic           in_fire, cfg_fire;
  logic [T_W-1:0] t_ext;
  logic           in_win, en_new, zp;

  ctpd_mul #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res),
    .stat_o  (mul_stat)
  );

  ctpd_div #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rate_q),
    .den_i   (dt_q),
    .res_o   (div_res),
    .stat_o  (div_stat)
  );

  // handshakes
  assign in_i.ready  = (state_q == ctpd_pkg::ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // window and enable decode of the incoming word
  assign t_ext  = T_W'(in_i.elapsed_time);
  assign in_win = (t_ext != '0) && (t_ext < T_END);
  assign en_new = en_q || (t_ext >= T_ONE);
  assign zp     = (dt_q == '0);

  // shared saturating adder
  assign add_sum  = add_sub ? ({add_a[WORD_BITS-1], add_a} - {add_b[WORD_BITS-1], add_b})
                            : ({add_a[WORD_BITS-1], add_a} + {add_b[WORD_BITS-1], add_b});
  assign add_clip = add_sum[WORD_BITS] != add_sum[WORD_BITS-1];
  assign add_res  = add_clip ? (add_sum[WORD_BITS] ? W_MIN : W_MAX)
                             : add_sum[WORD_BITS-1:0];

  // sequencer next state and datapath
  always_comb begin
    state_d   = state_q;
    t_d       = t_q;
    dt_d      = dt_q;
    ang_d     = ang_q;
    prev_d    = prev_q;
    en_d      = en_q;
    t2_d      = t2_q;
    t3_d      = t3_q;
    sp_d      = sp_q;
    err_d     = err_q;
    rate_d    = rate_q;
    prod_d    = prod_q;
    clip_d    = clip_q;
    wait_d    = wait_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    add_a     = '0;
    add_b     = '0;
    add_sub   = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      ctpd_pkg::ST_IDLE: begin
        if (in_fire) begin
          t_d    = in_i.elapsed_time;
          dt_d   = in_i.tick_period;
          ang_d  = in_i.joint_angle;
          en_d   = en_new;
          clip_d = 1'b0;
          if (!en_new) begin
            state_d = ctpd_pkg::ST_OUT;
          end else if (in_win) begin
            state_d = ctpd_pkg::ST_T2;
          end else begin
            sp_d    = hold_q;
            state_d = ctpd_pkg::ST_ERR;
          end
        end
      end
      // t squared
      ctpd_pkg::ST_T2: begin
        mul_a     = {1'b0, t_q};
        mul_b     = {1'b0, t_q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          t2_d    = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_T3;
        end
      end
      // t cubed
      ctpd_pkg::ST_T3: begin
        mul_a     = {t2_q[WORD_BITS-1], t2_q};
        mul_b     = {1'b0, t_q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          t3_d    = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_P1;
        end
      end
      ctpd_pkg::ST_P1: begin
        mul_a     = {c1_q[WORD_BITS-1], c1_q};
        mul_b     = {1'b0, t_q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          prod_d  = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_S1;
        end
      end
      ctpd_pkg::ST_S1: begin
        add_a   = c0_q;
        add_b   = prod_q;
        sp_d    = add_res;
        clip_d  = clip_q | add_clip;
        state_d = ctpd_pkg::ST_P2;
      end
      ctpd_pkg::ST_P2: begin
        mul_a     = {c2_q[WORD_BITS-1], c2_q};
        mul_b     = {t2_q[WORD_BITS-1], t2_q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          prod_d  = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_S2;
        end
      end
      ctpd_pkg::ST_S2: begin
        add_a   = sp_q;
        add_b   = prod_q;
        sp_d    = add_res;
        clip_d  = clip_q | add_clip;
        state_d = ctpd_pkg::ST_P3;
      end
      ctpd_pkg::ST_P3: begin
        mul_a     = {c3_q[WORD_BITS-1], c3_q};
        mul_b     = {t3_q[WORD_BITS-1], t3_q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          prod_d  = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_S3;
        end
      end
      ctpd_pkg::ST_S3: begin
        add_a   = sp_q;
        add_b   = prod_q;
        sp_d    = add_res;
        clip_d  = clip_q | add_clip;
        state_d = ctpd_pkg::ST_ERR;
      end
      // position error
      ctpd_pkg::ST_ERR: begin
        add_a   = sp_q;
        add_b   = ang_q;
        add_sub = 1'b1;
        err_d   = add_res;
        clip_d  = clip_q | add_clip;
        state_d = ctpd_pkg::ST_DIFF;
      end
      // angle difference, rate forced to zero for a zero period
      ctpd_pkg::ST_DIFF: begin
        add_a   = ang_q;
        add_b   = prev_q;
        add_sub = 1'b1;
        clip_d  = clip_q | add_clip;
        if (zp) begin
          rate_d  = '0;
          state_d = ctpd_pkg::ST_PK;
        end else begin
          rate_d  = add_res;
          state_d = ctpd_pkg::ST_RATE;
        end
      end
      ctpd_pkg::ST_RATE: begin
        div_start = !wait_q;
        if (div_stat.done) begin
          rate_d  = div_res;
          clip_d  = clip_q | div_stat.clip;
          state_d = ctpd_pkg::ST_PK;
        end
      end
      ctpd_pkg::ST_PK: begin
        mul_a     = {gp_q[WORD_BITS-1], gp_q};
        mul_b     = {err_q[WORD_BITS-1], err_q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          prod_d  = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_PD;
        end
      end
      ctpd_pkg::ST_PD: begin
        mul_a     = {gd_q[WORD_BITS-1], gd_q};
        mul_b     = {rate_q[WORD_BITS-1], rate_q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          rate_d  = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_U;
        end
      end
      ctpd_pkg::ST_U: begin
        add_a   = prod_q;
        add_b   = rate_q;
        add_sub = 1'b1;
        sp_d    = add_res;
        clip_d  = clip_q | add_clip;
        state_d = ctpd_pkg::ST_EFF;
      end
      // scale by one tenth
      ctpd_pkg::ST_EFF: begin
        mul_a     = {sp_q[WORD_BITS-1], sp_q};
        mul_b     = {1'b0, TENTH_Q};
        mul_start = !wait_q;
        if (mul_stat.done) begin
          prod_d  = mul_res;
          clip_d  = clip_q | mul_stat.clip;
          state_d = ctpd_pkg::ST_OUT;
        end
      end
      // hand the word to the output register
      ctpd_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          prev_d   = ang_q;
          state_d  = ctpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ctpd_pkg::ST_IDLE;
      end
    endcase

    // a unit request is outstanding from start until done
    if (mul_start || div_start) begin
      wait_d = 1'b1;
    end
    if (mul_stat.done || div_stat.done) begin
      wait_d = 1'b0;
    end
  end

  assign out_valid_d = (out_valid_q && !out_o.ready) || out_load;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctpd_pkg::ST_IDLE;
      en_q        <= 1'b0;
      prev_q      <= '0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      prev_q      <= prev_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    dt_q   <= dt_d;
    ang_q  <= ang_d;
    t2_q   <= t2_d;
    t3_q   <= t3_d;
    sp_q   <= sp_d;
    err_q  <= err_d;
    rate_q <= rate_d;
    prod_q <= prod_d;
    clip_q <= clip_d;
    if (out_load) begin
      out_eff_q <= en_q ? prod_q : '0;
      out_en_q  <= en_q;
      out_zp_q  <= zp;
      out_sat_q <= en_q && clip_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q   <= '0;
      gd_q   <= '0;
      c0_q   <= '0;
      c1_q   <= '0;
      c2_q   <= '0;
      c3_q   <= '0;
      hold_q <= HOLD_RESET;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        ctpd_pkg::REG_GAIN_PROP:  gp_q   <= cfg_i.data;
        ctpd_pkg::REG_GAIN_DERIV: gd_q   <= cfg_i.data;
        ctpd_pkg::REG_COEF_CONST: c0_q   <= cfg_i.data;
        ctpd_pkg::REG_COEF_LIN:   c1_q   <= cfg_i.data;
        ctpd_pkg::REG_COEF_QUAD:  c2_q   <= cfg_i.data;
        ctpd_pkg::REG_COEF_CUBE:  c3_q   <= cfg_i.data;
        ctpd_pkg::REG_HOLD_ANGLE: hold_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // outputs
  assign out_o.valid        = out_valid_q;
  assign out_o.effort_cmd   = out_eff_q;
  assign out_o.loop_enabled = out_en_q;
  assign out_o.zero_period  = out_zp_q;
  assign out_o.saturated    = out_sat_q;

`ifndef SYNTHESIS
  // the enable latch never drops once set
  a_enable_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_q |=> en_q)
    else $error("enable latch cleared after being set");

  // a disabled loop reports zero effort and no clipping
  a_disabled_effort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_en_q) |-> ((out_eff_q == '0) && !out_sat_q))
    else $error("nonzero effort while loop disabled");

  // a unit only finishes on an outstanding request
  a_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_stat.done || div_stat.done) |-> wait_q)
    else $error("arithmetic unit finished without a request");
`endif

endmodule

`default_nettype wire
